### design/ouart_pkg.sv
// Shared constants, types and helpers for the oversampled UART with FIFOs.
`default_nettype none

package ouart_pkg;

    // FIFO geometry
    localparam int TX_DEPTH = 256;
    localparam int RX_DEPTH = 128;
    localparam int TX_PTR_W = $clog2(TX_DEPTH);
    localparam int RX_PTR_W = $clog2(RX_DEPTH);

    // Word and frame geometry
    localparam int BYTE_W     = 8;
    localparam int DATA_BITS  = 8;
    localparam int FRAME_BITS = 10;
    localparam int BIT_IDX_W  = 4;
    localparam int TICK_CNT_W = 4;
    localparam int RX_CD_W    = 5;

    // Oversampling register
    localparam int TPB_W     = 5;
    localparam int TPB_MIN   = 4;
    localparam int TPB_MAX   = 16;
    localparam int TPB_RESET = 8;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_PUSH = 2'd1,
        KIND_POP  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_STORED   = 2'd1,
        EV_FRAMING  = 2'd2,
        EV_OVERRUN  = 2'd3
    } rx_event_t;

    // Decoded item, qualified by the input handshake
    typedef struct packed {
        logic tick;
        logic push;
        logic pop;
    } item_cmd_t;

    typedef struct packed {
        logic line;
        logic accepted;
    } tx_status_t;

    typedef struct packed {
        logic      valid;
        rx_event_t ev;
    } rx_status_t;

    // Clamp the written register into the usable range
    function automatic logic [TPB_W-1:0] clamp_tpb(input logic [TPB_W-1:0] raw);
        logic [TPB_W-1:0] res;
        begin
            res = raw;
            if (raw < TPB_W'(TPB_MIN))
            begin
                res = TPB_W'(TPB_MIN);
            end
            else if (raw > TPB_W'(TPB_MAX))
            begin
                res = TPB_W'(TPB_MAX);
            end
            return res;
        end
    endfunction

endpackage

`default_nettype wire

### design/ouart_if.sv
// Valid/ready channel interfaces for items, results and the configuration word.
`default_nettype none

interface ouart_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       rx_pin;
    logic [7:0] tx_data;

    modport source (output valid, output kind, output rx_pin, output tx_data, input ready);
    modport sink   (input valid, input kind, input rx_pin, input tx_data, output ready);
endinterface

interface ouart_result_if;
    logic       valid;
    logic       ready;
    logic       tx_line;
    logic       tx_accepted;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic [1:0] rx_event;

    modport source (output valid, output tx_line, output tx_accepted, output rx_valid,
                    output rx_data, output rx_event, input ready);
    modport sink   (input valid, input tx_line, input tx_accepted, input rx_valid,
                    input rx_data, input rx_event, output ready);
endinterface

interface ouart_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/ouart_tx.sv
// Transmit FIFO memory and 8N1 frame serializer.
`default_nettype none

module ouart_tx (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ouart_pkg::item_cmd_t        cmd,
    input  wire logic [ouart_pkg::BYTE_W-1:0] push_data,
    input  wire logic [ouart_pkg::TPB_W-1:0]  tpb,
    output ouart_pkg::tx_status_t            status
);
    import ouart_pkg::*;

    logic [BYTE_W-1:0]     store [TX_DEPTH];
    logic [BYTE_W-1:0]     rd_q;

    logic [TX_PTR_W-1:0]   head_reg, head_next;
    logic [TX_PTR_W-1:0]   tail_reg, tail_next;
    logic                  busy_reg, busy_next;
    logic [BYTE_W-1:0]     byte_reg, byte_next;
    logic [BIT_IDX_W-1:0]  idx_reg, idx_next;
    logic [TICK_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  level_reg, level_next;
    logic                  fetch_reg, fetch_next;

    logic                  wr_en;
    logic                  rd_en;
    logic                  accepted;
    logic                  load;
    logic                  frame_bit;
    logic [BIT_IDX_W-1:0]  data_sel;
    logic [TPB_W-1:0]      cnt_inc;
    logic [BIT_IDX_W-1:0]  idx_inc;

    function automatic logic [TX_PTR_W-1:0] ptr_inc(input logic [TX_PTR_W-1:0] p);
        begin
            return (p == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
        end
    endfunction

    // Pick the level of the current frame bit: start, data LSB first, stop
    always_comb
    begin
        data_sel = idx_reg - 1'b1;
        if (idx_reg == '0)
        begin
            frame_bit = 1'b0;
        end
        else if (idx_reg == BIT_IDX_W'(FRAME_BITS - 1))
        begin
            frame_bit = 1'b1;
        end
        else
        begin
            frame_bit = byte_reg[data_sel[$clog2(DATA_BITS)-1:0]];
        end
    end

    // Advance the serializer and the FIFO pointers for one item
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        level_next = level_reg;
        fetch_next = 1'b0;
        byte_next  = fetch_reg ? rd_q : byte_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        accepted   = 1'b0;
        load       = 1'b0;
        cnt_inc    = TPB_W'(cnt_reg) + 1'b1;
        idx_inc    = idx_reg + 1'b1;

        if (cmd.push)
        begin
            if (ptr_inc(head_reg) != tail_reg)
            begin
                wr_en     = 1'b1;
                accepted  = 1'b1;
                head_next = ptr_inc(head_reg);
                // idle means the FIFO was empty, so the pushed word is the one loaded
                if (!busy_reg)
                begin
                    byte_next = push_data;
                    tail_next = ptr_inc(tail_reg);
                    busy_next = 1'b1;
                    idx_next  = '0;
                    cnt_next  = '0;
                end
            end
        end
        else if (cmd.tick)
        begin
            if (!busy_reg)
            begin
                load = 1'b1;
            end
            else
            begin
                if (cnt_reg == '0 && idx_reg < BIT_IDX_W'(FRAME_BITS))
                begin
                    level_next = frame_bit;
                end
                if (cnt_inc >= tpb)
                begin
                    cnt_next = '0;
                    idx_next = idx_inc;
                    if (idx_inc >= BIT_IDX_W'(FRAME_BITS))
                    begin
                        busy_next  = 1'b0;
                        level_next = 1'b1;
                        load       = 1'b1;
                    end
                end
                else
                begin
                    cnt_next = cnt_inc[TICK_CNT_W-1:0];
                end
            end
            // fetch the next queued word; its data bits are needed ticks later
            if (load && head_reg != tail_reg)
            begin
                rd_en      = 1'b1;
                fetch_next = 1'b1;
                tail_next  = ptr_inc(tail_reg);
                busy_next  = 1'b1;
                idx_next   = '0;
                cnt_next   = '0;
            end
        end
    end

    // FIFO memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[head_reg] <= push_data;
        end
        if (rd_en)
        begin
            rd_q <= store[tail_reg];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            level_reg <= 1'b1;
            fetch_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            level_reg <= level_next;
            fetch_reg <= fetch_next;
        end
    end

    // Hold the word being sent
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign status.line     = level_next;
    assign status.accepted = accepted;

endmodule

`default_nettype wire

### design/ouart_rx.sv
// Receive deserializer and receive FIFO memory.
`default_nettype none

module ouart_rx (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ouart_pkg::item_cmd_t         cmd,
    input  wire logic                         pin,
    input  wire logic [ouart_pkg::TPB_W-1:0]   tpb,
    output ouart_pkg::rx_status_t             status,
    output logic [ouart_pkg::BYTE_W-1:0]       rd_data
);
    import ouart_pkg::*;

    logic [BYTE_W-1:0]    store [RX_DEPTH];

    logic [RX_PTR_W-1:0]  head_reg, head_next;
    logic [RX_PTR_W-1:0]  tail_reg, tail_next;
    logic                 busy_reg, busy_next;
    logic [BIT_IDX_W-1:0] idx_reg, idx_next;
    logic [BYTE_W-1:0]    shift_reg, shift_next;
    logic [RX_CD_W-1:0]   cd_reg, cd_next;
    logic                 prev_reg, prev_next;

    logic                 start;
    logic                 busy1;
    logic [RX_CD_W-1:0]   cd1;
    logic [RX_CD_W-1:0]   cd2;
    logic [BIT_IDX_W-1:0] idx1;
    logic [BYTE_W-1:0]    shift1;
    logic                 wr_en;
    logic                 rd_en;
    logic                 pop_valid;
    rx_event_t            ev;

    function automatic logic [RX_PTR_W-1:0] ptr_inc(input logic [RX_PTR_W-1:0] p);
        begin
            return (p == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
        end
    endfunction

    // Detect the start edge, count down to mid-bit, sample and store
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        shift_next = shift_reg;
        cd_next    = cd_reg;
        prev_next  = prev_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        pop_valid  = 1'b0;
        ev         = EV_NONE;

        start  = cmd.tick && !busy_reg && prev_reg && !pin;
        busy1  = busy_reg || start;
        cd1    = start ? (RX_CD_W'(tpb) + RX_CD_W'(tpb >> 1)) : cd_reg;
        idx1   = start ? '0 : idx_reg;
        shift1 = start ? '0 : shift_reg;
        cd2    = (cd1 != '0) ? cd1 - 1'b1 : cd1;

        if (cmd.tick)
        begin
            prev_next  = pin;
            busy_next  = busy1;
            idx_next   = idx1;
            shift_next = shift1;
            cd_next    = cd1;
            if (busy1)
            begin
                cd_next = cd2;
                if (cd2 == '0)
                begin
                    if (idx1 < BIT_IDX_W'(DATA_BITS))
                    begin
                        shift_next = shift1 | (BYTE_W'(pin) << idx1[$clog2(DATA_BITS)-1:0]);
                        idx_next   = idx1 + 1'b1;
                        cd_next    = RX_CD_W'(tpb);
                    end
                    else
                    begin
                        busy_next = 1'b0;
                        if (!pin)
                        begin
                            ev = EV_FRAMING;
                        end
                        else if (ptr_inc(head_reg) != tail_reg)
                        begin
                            wr_en     = 1'b1;
                            head_next = ptr_inc(head_reg);
                            ev        = EV_STORED;
                        end
                        else
                        begin
                            ev = EV_OVERRUN;
                        end
                    end
                end
            end
        end
        else if (cmd.pop)
        begin
            if (head_reg != tail_reg)
            begin
                rd_en     = 1'b1;
                pop_valid = 1'b1;
                tail_next = ptr_inc(tail_reg);
            end
        end
    end

    // FIFO memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[head_reg] <= shift_reg;
        end
        if (rd_en)
        begin
            rd_data <= store[tail_reg];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            shift_reg <= '0;
            cd_reg    <= '0;
            prev_reg  <= 1'b1;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            shift_reg <= shift_next;
            cd_reg    <= cd_next;
            prev_reg  <= prev_next;
        end
    end

    assign status.valid = pop_valid;
    assign status.ev    = ev;

endmodule

`default_nettype wire

### design/oversampled_uart_with_fifos_top.sv
// Top level: 8N1 UART with transmit and receive FIFOs, item and result channels.
//
// One item (oversampling tick, push of a transmit word, or pop of a received
// word) is taken every clock cycle unless both result stages are full and
// stalled. Each item yields exactly one result word, which moves through result
// stage A, then stage B, to the result channel; stage A waits on the registered
// receive FIFO read port that supplies rx_data. A two-deep result stage lets the
// block keep taking items while one result waits. The FIFO memories need no
// clearing pass: ring pointers alone track which words are live, so the block
// takes items as soon as reset is released. ticks_per_bit may be written at any
// time the block is idle; values below 4 act as 4 and above 16 act as 16.
`default_nettype none

module oversampled_uart_with_fifos_top (
    input  wire logic      clk,
    input  wire logic      rst_n,
    ouart_item_if.sink     item,
    ouart_result_if.source result,
    ouart_cfg_if.sink      cfg
);
    import ouart_pkg::*;

    logic [TPB_W-1:0]  tpb_reg;
    logic [TPB_W-1:0]  tpb;

    logic              accept;
    item_cmd_t         cmd;
    tx_status_t        tx_status;
    rx_status_t        rx_status;
    logic [BYTE_W-1:0] rx_rd_data;

    // Stage A: result just computed, rx_data still at the FIFO read port
    logic              a_valid_reg, a_valid_next;
    tx_status_t        a_tx_reg;
    rx_status_t        a_rx_reg;

    // Stage B: result shown on the port
    logic              b_valid_reg, b_valid_next;
    tx_status_t        b_tx_reg;
    rx_status_t        b_rx_reg;
    logic [BYTE_W-1:0] b_data_reg;

    logic              a_move;

    // Configuration register, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpb_reg <= TPB_W'(TPB_RESET);
        end
        else if (cfg.valid)
        begin
            tpb_reg <= cfg.data;
        end
    end

    assign tpb = clamp_tpb(tpb_reg);

    // Decode the accepted item
    assign a_move     = a_valid_reg && (!b_valid_reg || result.ready);
    assign item.ready = !a_valid_reg || a_move;
    assign accept     = item.valid && item.ready;
    assign cmd.tick   = accept && (item.kind == KIND_TICK);
    assign cmd.push   = accept && (item.kind == KIND_PUSH);
    assign cmd.pop    = accept && (item.kind == KIND_POP);

    ouart_tx u_tx (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .push_data (item.tx_data),
        .tpb       (tpb),
        .status    (tx_status)
    );

    ouart_rx u_rx (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .pin     (item.rx_pin),
        .tpb     (tpb),
        .status  (rx_status),
        .rd_data (rx_rd_data)
    );

    // Advance the two result stages
    always_comb
    begin
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_move)
        begin
            a_valid_next = 1'b0;
        end
        if (a_move)
        begin
            b_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Result payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_tx_reg <= tx_status;
            a_rx_reg <= rx_status;
        end
        if (a_move)
        begin
            b_tx_reg   <= a_tx_reg;
            b_rx_reg   <= a_rx_reg;
            b_data_reg <= a_rx_reg.valid ? rx_rd_data : '0;
        end
    end

    assign result.valid       = b_valid_reg;
    assign result.tx_line     = b_tx_reg.line;
    assign result.tx_accepted = b_tx_reg.accepted;
    assign result.rx_valid    = b_rx_reg.valid;
    assign result.rx_data     = b_data_reg;
    assign result.rx_event    = b_rx_reg.ev;

endmodule

`default_nettype wire

### design/ouart_checker.sv
// Port-level checks for the UART top level, attached by bind.
`default_nettype none

module ouart_port_checks (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       item_valid,
    input wire logic       item_ready,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic       tx_line,
    input wire logic       tx_accepted,
    input wire logic       rx_valid,
    input wire logic [7:0] rx_data,
    input wire logic [1:0] rx_event
);
    import ouart_pkg::*;

    // A stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid
            && $stable({tx_line, tx_accepted, rx_valid, rx_data, rx_event}))
        else $error("result word changed while stalled");

    // A taken item is followed by a valid result word after result stages A and B
    a_item_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |-> ##2 res_valid)
        else $error("taken item produced no result");

    // Input stalls only when both result stages are full and blocked
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> res_valid && !res_ready)
        else $error("input stalled with room in the result stages");

    // A result reports at most one kind of activity, and data only with a pop
    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!(tx_accepted && rx_valid))
            && (rx_event == EV_NONE || (!tx_accepted && !rx_valid))
            && (rx_valid || rx_data == '0))
        else $error("inconsistent result word");

endmodule

bind oversampled_uart_with_fifos_top ouart_port_checks u_ouart_port_checks (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item.valid),
    .item_ready  (item.ready),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .tx_line     (result.tx_line),
    .tx_accepted (result.tx_accepted),
    .rx_valid    (result.rx_valid),
    .rx_data     (result.rx_data),
    .rx_event    (result.rx_event)
);

`default_nettype wire
